[hw/rtl/bankers_safety_allocator_core_assert.svh]
// assertion macros for the allocator core
`ifndef BANKERS_SAFETY_ALLOCATOR_CORE_ASSERT_SVH
`define BANKERS_SAFETY_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTH
`define BSA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BSA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BSA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BSA_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/bsa_pkg.sv]
`timescale 1ns / 1ps
package bsa_pkg;
  localparam int PROCS_DEF = 5;
  localparam int RES_DEF = 3;
  localparam int UNIT_W = 8;
  localparam int NUM_AMT = 3;
  localparam int STATUS_W = 3;
  localparam int KIND_W = 2;
  localparam int PROC_FW = 3;
  localparam int DATA_W = 32;
  localparam logic [UNIT_W-1:0] RESET_TOTAL = 8'd10;
  localparam logic [UNIT_W-1:0] RESET_CLAIM = 8'd3;

  localparam logic [KIND_W-1:0] KIND_REQ = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REINIT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OVER_NEED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SHORT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNSAFE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVER_ALLOC = 3'd4;

  localparam logic CFG_TOTAL = 1'b0;
  localparam logic CFG_CLAIM = 1'b1;

  typedef struct packed {
    logic over_need;
    logic short_free;
    logic over_alloc;
    logic fits;
  } check_t;
endpackage

[hw/rtl/bsa_table.sv]
`timescale 1ns / 1ps
module bsa_table #(
  parameter int PROCS = 5,
  parameter int RESOURCES = 3,
  parameter int IDXW = 3
) (
  input  logic clk,
  input  logic rst,
  input  logic clear,
  input  logic [bsa_pkg::UNIT_W-1:0] init_need,
  input  logic wr_en,
  input  logic [IDXW-1:0] wr_addr,
  input  logic [RESOURCES-1:0][bsa_pkg::UNIT_W-1:0] wr_alloc,
  input  logic [RESOURCES-1:0][bsa_pkg::UNIT_W-1:0] wr_need,
  input  logic rd_en,
  input  logic [IDXW-1:0] rd_addr,
  output logic [RESOURCES-1:0][bsa_pkg::UNIT_W-1:0] rd_alloc,
  output logic [RESOURCES-1:0][bsa_pkg::UNIT_W-1:0] rd_need
);
  import bsa_pkg::*;

  logic [RESOURCES-1:0][UNIT_W-1:0] mem_alloc [PROCS];
  logic [RESOURCES-1:0][UNIT_W-1:0] mem_need [PROCS];
  logic [PROCS-1:0] row_vld;
  logic [RESOURCES-1:0][UNIT_W-1:0] alloc_q;
  logic [RESOURCES-1:0][UNIT_W-1:0] need_q;
  logic vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_alloc[wr_addr] <= wr_alloc;
      mem_need[wr_addr] <= wr_need;
    end
    if (rd_en) begin
      alloc_q <= mem_alloc[rd_addr];
      need_q <= mem_need[rd_addr];
    end
  end

  // rows never written since init read as their init values
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row_vld <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr_en) row_vld[wr_addr] <= 1'b1;
      if (rd_en) vld_q <= row_vld[rd_addr];
    end
  end

  always_comb begin
    for (int r = 0; r < RESOURCES; r++) begin
      rd_alloc[r] = vld_q ? alloc_q[r] : '0;
      rd_need[r] = vld_q ? need_q[r] : init_need;
    end
  end
endmodule

[hw/rtl/bsa_row_check.sv]
`timescale 1ns / 1ps
module bsa_row_check #(
  parameter int RESOURCES = 3
) (
  input  logic [RESOURCES-1:0][bsa_pkg::UNIT_W-1:0] amt,
  input  logic [RESOURCES-1:0][bsa_pkg::UNIT_W-1:0] alloc,
  input  logic [RESOURCES-1:0][bsa_pkg::UNIT_W-1:0] need,
  input  logic [RESOURCES-1:0][bsa_pkg::UNIT_W-1:0] free_units,
  input  logic [RESOURCES-1:0][bsa_pkg::UNIT_W-1:0] pool,
  input  logic done,
  output bsa_pkg::check_t chk
);
  import bsa_pkg::*;

  always_comb begin
    chk.over_need = 1'b0;
    chk.short_free = 1'b0;
    chk.over_alloc = 1'b0;
    chk.fits = !done;
    for (int r = 0; r < RESOURCES; r++) begin
      if (amt[r] > need[r]) chk.over_need = 1'b1;
      if (amt[r] > free_units[r]) chk.short_free = 1'b1;
      if (amt[r] > alloc[r]) chk.over_alloc = 1'b1;
      if (need[r] > pool[r]) chk.fits = 1'b0;
    end
  end
endmodule

[hw/rtl/bankers_safety_allocator_core.sv]
// re-initialize, unused kind or bad process go from S_IDLE straight to S_RESP; release is checked in S_CHECK
// request: refused in S_CHECK, else the safety walk makes up to PROCS passes over the table
// one word in flight; throughput bound by the safety walk, one table row read per cycle
// rst clears tables to zero allocation, need 3, free 10; registers to 10 and 3
// re-initialize reloads the tables from the registers
`timescale 1ns / 1ps
module bankers_safety_allocator_core #(
  parameter int PROCS = bsa_pkg::PROCS_DEF,
  parameter int RESOURCES = bsa_pkg::RES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [bsa_pkg::DATA_W-1:0] s_axis_tdata,  // process, amount_0, amount_1, amount_2
  input  logic [bsa_pkg::KIND_W-1:0] s_axis_tuser,  // kind
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [bsa_pkg::DATA_W-1:0] m_axis_tdata,  // status, free_0, free_1, free_2
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [bsa_pkg::UNIT_W-1:0] cfg_data
);
  import bsa_pkg::*;
  `include "bankers_safety_allocator_core_assert.svh"

  localparam int IDXW = (PROCS > 1) ? $clog2(PROCS) : 1;
  localparam int PIW0 = $clog2(PROCS + 1);
  localparam int PIW = (PIW0 > PROC_FW) ? PIW0 : PROC_FW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  typedef logic [RESOURCES-1:0][UNIT_W-1:0] row_t;

  logic [1:0] state;
  logic [KIND_W-1:0] kind_q;
  logic [IDXW-1:0] proc_q;
  row_t amt_q, free_units, pool, orig_alloc, orig_need;
  logic [UNIT_W-1:0] total_units, max_claim, init_need;
  logic [PROCS-1:0] done_mask, done_new;
  logic progress;
  logic [IDXW-1:0] rd_ptr, cmp_ptr;
  logic cmp_vld;
  logic [STATUS_W-1:0] status_q;

  logic accept;
  logic [PIW-1:0] proc_wide;
  logic in_range;
  logic tbl_clear, tbl_wr, tbl_rd;
  logic [IDXW-1:0] tbl_rd_addr;
  row_t wr_alloc, wr_need, rd_alloc, rd_need, amt_in;
  check_t chk;
  logic last_cmp, pass_prog, all_done;
  logic resp_fire;
  logic [DATA_W-1:0] resp_word;

  assign s_axis_tready = (state == S_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign proc_wide = PIW'(s_axis_tdata[PROC_FW-1:0]);
  assign in_range = proc_wide < PIW'(PROCS);
  assign tbl_clear = accept && (s_axis_tuser == KIND_REINIT);
  assign resp_fire = (state == S_RESP) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    for (int r = 0; r < RESOURCES; r++)
      amt_in[r] = s_axis_tdata[PROC_FW + UNIT_W*r +: UNIT_W];
  end

  always_comb begin
    tbl_rd = 1'b0;
    tbl_rd_addr = rd_ptr;
    if (accept && in_range && (s_axis_tuser == KIND_REQ || s_axis_tuser == KIND_REL)) begin
      tbl_rd = 1'b1;
      tbl_rd_addr = proc_wide[IDXW-1:0];
    end else if (state == S_WALK) begin
      tbl_rd = 1'b1;
    end
  end

  bsa_row_check #(.RESOURCES(RESOURCES)) u_check (
    .amt(amt_q),
    .alloc(rd_alloc),
    .need(rd_need),
    .free_units(free_units),
    .pool(pool),
    .done(done_mask[cmp_ptr]),
    .chk(chk)
  );

  assign last_cmp = cmp_vld && (cmp_ptr == IDXW'(PROCS - 1));
  assign pass_prog = progress || (cmp_vld && chk.fits);
  always_comb begin
    done_new = done_mask;
    if (cmp_vld && chk.fits) done_new[cmp_ptr] = 1'b1;
  end
  assign all_done = (done_new == {PROCS{1'b1}});

  always_comb begin
    tbl_wr = 1'b0;
    wr_alloc = orig_alloc;
    wr_need = orig_need;
    if (state == S_CHECK) begin
      for (int r = 0; r < RESOURCES; r++) begin
        if (kind_q == KIND_REL) begin
          wr_alloc[r] = rd_alloc[r] - amt_q[r];
          wr_need[r] = rd_need[r] + amt_q[r];
        end else begin
          wr_alloc[r] = rd_alloc[r] + amt_q[r];
          wr_need[r] = rd_need[r] - amt_q[r];
        end
      end
      tbl_wr = (kind_q == KIND_REL) ? !chk.over_alloc : !(chk.over_need || chk.short_free);
    end else if (state == S_WALK && last_cmp && (!pass_prog || all_done)) begin
      tbl_wr = !all_done;
    end
  end

  bsa_table #(.PROCS(PROCS), .RESOURCES(RESOURCES), .IDXW(IDXW)) u_table (
    .clk(clk),
    .rst(rst),
    .clear(tbl_clear),
    .init_need(init_need),
    .wr_en(tbl_wr),
    .wr_addr(proc_q),
    .wr_alloc(wr_alloc),
    .wr_need(wr_need),
    .rd_en(tbl_rd),
    .rd_addr(tbl_rd_addr),
    .rd_alloc(rd_alloc),
    .rd_need(rd_need)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      total_units <= RESET_TOTAL;
      max_claim <= RESET_CLAIM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOTAL: total_units <= cfg_data;
        CFG_CLAIM: max_claim <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      init_need <= RESET_CLAIM;
      for (int r = 0; r < RESOURCES; r++) free_units[r] <= RESET_TOTAL;
      cmp_vld <= 1'b0;
    end else begin
      if (resp_fire) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            kind_q <= s_axis_tuser;
            proc_q <= proc_wide[IDXW-1:0];
            amt_q <= amt_in;
            if (s_axis_tuser == KIND_REINIT) begin
              state <= S_RESP;
              status_q <= ST_DONE;
              init_need <= max_claim;
              for (int r = 0; r < RESOURCES; r++) free_units[r] <= total_units;
            end else if ((s_axis_tuser == KIND_REQ || s_axis_tuser == KIND_REL) && in_range) begin
              state <= S_CHECK;
              status_q <= ST_DONE;
            end else if (s_axis_tuser == KIND_REQ) begin
              state <= S_RESP;
              status_q <= ST_OVER_NEED;
            end else if (s_axis_tuser == KIND_REL) begin
              state <= S_RESP;
              status_q <= ST_OVER_ALLOC;
            end else begin
              state <= S_RESP;
              status_q <= ST_DONE;
            end
          end
        end
        S_CHECK: begin
          orig_alloc <= rd_alloc;
          orig_need <= rd_need;
          if (kind_q == KIND_REL) begin
            state <= S_RESP;
            if (chk.over_alloc) begin
              status_q <= ST_OVER_ALLOC;
            end else begin
              for (int r = 0; r < RESOURCES; r++) free_units[r] <= free_units[r] + amt_q[r];
            end
          end else if (chk.over_need) begin
            state <= S_RESP;
            status_q <= ST_OVER_NEED;
          end else if (chk.short_free) begin
            state <= S_RESP;
            status_q <= ST_SHORT;
          end else begin
            for (int r = 0; r < RESOURCES; r++) begin
              free_units[r] <= free_units[r] - amt_q[r];
              pool[r] <= free_units[r] - amt_q[r];
            end
            done_mask <= '0;
            progress <= 1'b0;
            rd_ptr <= '0;
            cmp_vld <= 1'b0;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          rd_ptr <= (rd_ptr == IDXW'(PROCS - 1)) ? '0 : rd_ptr + 1'b1;
          cmp_ptr <= rd_ptr;
          done_mask <= done_new;
          if (cmp_vld && chk.fits) begin
            for (int r = 0; r < RESOURCES; r++) pool[r] <= pool[r] + rd_alloc[r];
          end
          if (last_cmp) begin
            progress <= 1'b0;
            if (!pass_prog || all_done) begin
              cmp_vld <= 1'b0;
              state <= S_RESP;
              if (all_done) begin
                status_q <= ST_DONE;
              end else begin
                status_q <= ST_UNSAFE;
                for (int r = 0; r < RESOURCES; r++)
                  free_units[r] <= free_units[r] + amt_q[r];
              end
            end else begin
              cmp_vld <= 1'b1;
            end
          end else begin
            progress <= pass_prog;
            cmp_vld <= 1'b1;
          end
        end
        S_RESP: begin
          if (resp_fire) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    resp_word = '0;
    resp_word[STATUS_W-1:0] = status_q;
    for (int r = 0; r < RESOURCES; r++)
      resp_word[STATUS_W + UNIT_W*r +: UNIT_W] = free_units[r];
  end

  always_ff @(posedge clk) begin
    if (resp_fire) m_axis_tdata <= resp_word;
  end

  `BSA_ASSERT_IMP(a_no_rw_clash, clk, rst, tbl_wr && tbl_rd, tbl_rd_addr != proc_q || state == S_WALK)
  `BSA_ASSERT_NXT(a_resp_sent, clk, rst, resp_fire, m_axis_tvalid && state == S_IDLE)
  `BSA_ASSERT_IMP(a_free_hold_walk, clk, rst, state == S_WALK && $past(state) == S_WALK, $stable(free_units))
endmodule

[test/bsa_checker.sv]
`timescale 1ns / 1ps
module bsa_checker (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  input  logic s_axis_tready,
  input  logic [bsa_pkg::DATA_W-1:0] s_axis_tdata,
  input  logic [bsa_pkg::KIND_W-1:0] s_axis_tuser,
  input  logic m_axis_tvalid,
  input  logic m_axis_tready,
  input  logic [bsa_pkg::DATA_W-1:0] m_axis_tdata,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [bsa_pkg::UNIT_W-1:0] cfg_data,
  output int fail_count,
  output int pending,
  output int results_seen,
  output int grants,
  output int rollbacks
);
  import bsa_pkg::*;

  localparam int NP = PROCS_DEF;
  localparam int NR = RES_DEF;

  logic [7:0] total_reg, claim_reg;
  logic [7:0] held [NP][NR];
  logic [7:0] owed [NP][NR];
  logic [7:0] pool [NR];
  logic [DATA_W-1:0] expected_words [$];

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic reload_tables();
    for (int p = 0; p < NP; p++)
      for (int r = 0; r < NR; r++) begin
        held[p][r] = 8'd0;
        owed[p][r] = claim_reg;
      end
    for (int r = 0; r < NR; r++) pool[r] = total_reg;
  endtask

  function automatic bit all_can_finish();
    int work [NR];
    bit fin [NP];
    bit moved;
    bit ok;
    for (int r = 0; r < NR; r++) work[r] = int'(pool[r]);
    for (int p = 0; p < NP; p++) fin[p] = 0;
    moved = 1;
    while (moved) begin
      moved = 0;
      for (int p = 0; p < NP; p++) begin
        ok = !fin[p];
        for (int r = 0; r < NR; r++) if (int'(owed[p][r]) > work[r]) ok = 0;
        if (ok) begin
          for (int r = 0; r < NR; r++) work[r] += int'(held[p][r]);
          fin[p] = 1;
          moved = 1;
        end
      end
    end
    for (int p = 0; p < NP; p++) if (!fin[p]) return 0;
    return 1;
  endfunction

  task automatic predict_allocation(input logic [KIND_W-1:0] kind,
                                    input logic [DATA_W-1:0] word);
    logic [2:0] proc;
    logic [7:0] amt [NR];
    logic [STATUS_W-1:0] st;
    bit bad;
    proc = word[2:0];
    for (int r = 0; r < NR; r++) amt[r] = word[3 + 8*r +: 8];
    st = ST_DONE;
    if (kind == KIND_REQ) begin
      if (proc >= NP) st = ST_OVER_NEED;
      else begin
        bad = 0;
        for (int r = 0; r < NR; r++) if (amt[r] > owed[proc][r]) bad = 1;
        if (bad) st = ST_OVER_NEED;
        else begin
          for (int r = 0; r < NR; r++) if (amt[r] > pool[r]) bad = 1;
          if (bad) st = ST_SHORT;
          else begin
            for (int r = 0; r < NR; r++) begin
              held[proc][r] += amt[r];
              pool[r] -= amt[r];
              owed[proc][r] -= amt[r];
            end
            if (all_can_finish()) grants++;
            else begin
              st = ST_UNSAFE;
              rollbacks++;
              for (int r = 0; r < NR; r++) begin
                held[proc][r] -= amt[r];
                pool[r] += amt[r];
                owed[proc][r] += amt[r];
              end
            end
          end
        end
      end
    end else if (kind == KIND_REL) begin
      if (proc >= NP) st = ST_OVER_ALLOC;
      else begin
        bad = 0;
        for (int r = 0; r < NR; r++) if (amt[r] > held[proc][r]) bad = 1;
        if (bad) st = ST_OVER_ALLOC;
        else
          for (int r = 0; r < NR; r++) begin
            held[proc][r] -= amt[r];
            pool[r] += amt[r];
            owed[proc][r] += amt[r];
          end
      end
    end else if (kind == KIND_REINIT) begin
      reload_tables();
    end
    expected_words.push_back({5'd0, pool[2], pool[1], pool[0], st});
  endtask

  always @(posedge clk) begin
    logic [DATA_W-1:0] want;
    if (rst) begin
      total_reg <= RESET_TOTAL;
      claim_reg <= RESET_CLAIM;
      for (int p = 0; p < NP; p++)
        for (int r = 0; r < NR; r++) begin
          held[p][r] = 8'd0;
          owed[p][r] = RESET_CLAIM;
        end
      for (int r = 0; r < NR; r++) pool[r] = RESET_TOTAL;
      expected_words.delete();
      fail_count <= 0;
      results_seen <= 0;
      grants = 0;
      rollbacks = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_TOTAL) total_reg <= cfg_data;
        else claim_reg <= cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) predict_allocation(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen <= results_seen + 1;
        if (expected_words.size() == 0) begin
          $display("unexpected result word %h at %0t", m_axis_tdata, $realtime);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (m_axis_tdata[2:0] !== want[2:0]) report("status", m_axis_tdata[2:0], want[2:0]);
          if (m_axis_tdata[31:27] !== 5'd0) report("pad", m_axis_tdata[31:27], 8'd0);
          for (int r = 0; r < NR; r++)
            if (m_axis_tdata[3 + 8*r +: 8] !== want[3 + 8*r +: 8])
              report($sformatf("free_%0d", r), m_axis_tdata[3 + 8*r +: 8], want[3 + 8*r +: 8]);
        end
      end
    end
    pending = expected_words.size();
  end
endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import bsa_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic [KIND_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [DATA_W-1:0] m_axis_tdata;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [UNIT_W-1:0] cfg_data = '0;
  int fail_count, pending, results_seen, grants, rollbacks;
  int quiet_cycles;
  int sent;
  int stall_left;
  bit drain_phase;

  always #6 clk = ~clk;

  bankers_safety_allocator_core dut (.*);
  bsa_checker chk (.*);

  // receiver backpressure: random stall bursts, none near the end
  always @(posedge clk) begin
    if (rst || drain_phase) begin
      m_axis_tready <= 1'b1;
      stall_left <= 0;
    end else if (!m_axis_tready && stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!m_axis_tready) begin
      m_axis_tready <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= int'($urandom_range(0, 11));
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d words outstanding", pending);
      $display("bankers_safety_allocator_core regression: fail");
      $finish;
    end
  end

  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [2:0] proc,
                           input logic [7:0] a0, input logic [7:0] a1, input logic [7:0] a2);
    if (!drain_phase && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {5'd0, a2, a1, a0, proc};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly small amounts so grants happen, sometimes full range
  function automatic logic [7:0] pick_amount(input logic [7:0] claim);
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, claim > 4 ? 4 : claim));
  endfunction

  task automatic random_phase(input int count, input logic [7:0] claim);
    int roll;
    logic [KIND_W-1:0] k;
    logic [2:0] p;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) k = KIND_REQ;
      else if (roll < 92) k = KIND_REL;
      else if (roll < 97) k = KIND_REINIT;
      else k = KIND_UNUSED;
      p = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      if (k == KIND_REL && $urandom_range(0, 1))
        send_word(k, p, 8'($urandom_range(0, 2)), 8'($urandom_range(0, 2)),
                  8'($urandom_range(0, 2)));
      else send_word(k, p, pick_amount(claim), pick_amount(claim), pick_amount(claim));
    end
  endtask

  initial begin
    sent = 0;
    drain_phase = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset tables, extremes, all kinds, bad process, unused kind
    send_word(KIND_REQ, 3'd0, 8'd0, 8'd0, 8'd0);
    send_word(KIND_REQ, 3'd0, 8'd3, 8'd3, 8'd3);
    send_word(KIND_REQ, 3'd1, 8'd4, 8'd0, 8'd0);
    send_word(KIND_REQ, 3'd1, 8'd255, 8'd255, 8'd255);
    send_word(KIND_REQ, 3'd4, 8'd3, 8'd3, 8'd3);
    send_word(KIND_REQ, 3'd2, 8'd3, 8'd3, 8'd3);
    send_word(KIND_REQ, 3'd3, 8'd3, 8'd0, 8'd0);
    send_word(KIND_REL, 3'd0, 8'd255, 8'd0, 8'd0);
    send_word(KIND_REL, 3'd0, 8'd3, 8'd3, 8'd3);
    send_word(KIND_REL, 3'd1, 8'd0, 8'd0, 8'd0);
    send_word(KIND_REQ, 3'd5, 8'd0, 8'd0, 8'd0);
    send_word(KIND_REL, 3'd7, 8'd0, 8'd0, 8'd0);
    send_word(KIND_REQ, 3'd6, 8'd255, 8'd255, 8'd255);
    send_word(KIND_UNUSED, 3'd7, 8'd255, 8'd255, 8'd255);
    send_word(KIND_REINIT, 3'd0, 8'd0, 8'd0, 8'd0);
    wait_idle();

    // total below claim: state unsafe, zero request rolls back
    write_reg(CFG_TOTAL, 8'd2);
    write_reg(CFG_CLAIM, 8'd5);
    send_word(KIND_REINIT, 3'd0, 8'd0, 8'd0, 8'd0);
    send_word(KIND_REQ, 3'd0, 8'd0, 8'd0, 8'd0);
    send_word(KIND_REQ, 3'd0, 8'd2, 8'd2, 8'd2);
    send_word(KIND_REQ, 3'd1, 8'd3, 8'd0, 8'd0);
    wait_idle();

    write_reg(CFG_TOTAL, 8'd255);
    write_reg(CFG_CLAIM, 8'd255);
    send_word(KIND_REINIT, 3'd0, 8'd0, 8'd0, 8'd0);
    send_word(KIND_REQ, 3'd4, 8'd255, 8'd255, 8'd255);
    send_word(KIND_REL, 3'd4, 8'd255, 8'd255, 8'd255);
    send_word(KIND_REQ, 3'd2, 8'd128, 8'd64, 8'd1);
    wait_idle();

    write_reg(CFG_TOTAL, 8'd0);
    write_reg(CFG_CLAIM, 8'd0);
    send_word(KIND_REINIT, 3'd0, 8'd0, 8'd0, 8'd0);
    random_phase(60, 8'd0);
    wait_idle();

    write_reg(CFG_TOTAL, 8'd10);
    write_reg(CFG_CLAIM, 8'd3);
    send_word(KIND_REINIT, 3'd0, 8'd0, 8'd0, 8'd0);
    random_phase(350, 8'd3);
    wait_idle();

    write_reg(CFG_TOTAL, 8'd7);
    write_reg(CFG_CLAIM, 8'd4);
    send_word(KIND_REINIT, 3'd0, 8'd0, 8'd0, 8'd0);
    random_phase(300, 8'd4);
    wait_idle();

    write_reg(CFG_TOTAL, 8'd200);
    write_reg(CFG_CLAIM, 8'd60);
    send_word(KIND_REINIT, 3'd0, 8'd0, 8'd0, 8'd0);
    random_phase(200, 8'd60);
    wait_idle();

    write_reg(CFG_TOTAL, 8'd6);
    write_reg(CFG_CLAIM, 8'd3);
    send_word(KIND_REINIT, 3'd0, 8'd0, 8'd0, 8'd0);
    drain_phase = 1;
    random_phase(200, 8'd3);
    wait_idle();

    $display("%0d words sent, %0d results checked, %0d grants, %0d rollbacks",
             sent, results_seen, grants, rollbacks);
    $display("covered requests, releases, re-inits, bad process, unused kind, five settings");
    if (fail_count == 0 && pending == 0)
      $display("bankers_safety_allocator_core regression: pass");
    else
      $display("bankers_safety_allocator_core regression: fail");
    $finish;
  end
endmodule

[bankers_safety_allocator_core.f]
+incdir+hw/rtl
hw/rtl/bsa_pkg.sv
hw/rtl/bsa_table.sv
hw/rtl/bsa_row_check.sv
hw/rtl/bankers_safety_allocator_core.sv
test/bsa_checker.sv
test/tb_top.sv
